/* src/shf_pkg.sv */
// Shared types and constants for the sync header frame classifier.
// No dependencies; imported by every module of the block.
`default_nettype none

package shf_pkg;

   localparam logic [7:0] HDR_FIRST  = 8'h55;
   localparam logic [7:0] HDR_SECOND = 8'h35;
   localparam logic [3:0] BODY_START = 4'd2;
   localparam logic [3:0] LAST_INDEX = 4'd9;

   localparam logic [2:0] KIND_HEARTBEAT = 3'd0;
   localparam logic [2:0] KIND_STATUS    = 3'd1;
   localparam logic [2:0] KIND_CONTROL   = 3'd2;
   localparam logic [2:0] KIND_QUERY     = 3'd3;
   localparam logic [2:0] KIND_UNKNOWN   = 3'd4;

   localparam logic [1:0] CSR_HEARTBEAT = 2'd0;
   localparam logic [1:0] CSR_STATUS    = 2'd1;
   localparam logic [1:0] CSR_CONTROL   = 2'd2;
   localparam logic [1:0] CSR_QUERY     = 2'd3;

   typedef struct packed {
      logic [7:0] heartbeat;
      logic [7:0] status;
      logic [7:0] control;
      logic [7:0] query;
   } code_set_type;

   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] ftype;
      logic [7:0] len;
      logic [7:0] sub;
      logic [7:0] d1;
      logic [7:0] d2;
      logic [7:0] d3;
      logic [7:0] t1;
      logic [7:0] t2;
   } frame_rec_type;

endpackage

`default_nettype wire

/* src/shf_front.sv */
// Front end: header hunt, frame byte collection and kind classification.
// Depends on shf_pkg; pushes finished frames into shf_queue.
`default_nettype none

module shf_front
   import shf_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          in_valid,
   input  wire logic [7:0]    in_byte,
   input  wire code_set_type  codes,
   input  wire logic          queue_full,
   output logic               in_stall,
   output logic               push,
   output frame_rec_type      push_rec
);

   typedef enum logic [1:0] {
      PH_HUNT,
      PH_GOT55,
      PH_BODY
   } phase_type;

   phase_type  phase_ff;
   logic [3:0] index_ff;
   logic [7:0] bytes_ff [7];
   logic       accept;
   logic [2:0] slot;
   logic [3:0] index_sum;

   assign in_stall  = queue_full;
   assign accept    = in_valid && !queue_full;
   assign index_sum = index_ff - BODY_START;
   assign slot      = index_sum[2:0];
   assign push      = accept && (phase_ff == PH_BODY) && (index_ff == LAST_INDEX);

   always_comb begin
      push_rec.ftype = bytes_ff[2];
      push_rec.len   = bytes_ff[0];
      push_rec.sub   = bytes_ff[1];
      push_rec.d1    = bytes_ff[3];
      push_rec.d2    = bytes_ff[4];
      push_rec.d3    = bytes_ff[5];
      push_rec.t1    = bytes_ff[6];
      push_rec.t2    = in_byte;
      priority if (bytes_ff[2] == codes.heartbeat) push_rec.kind = KIND_HEARTBEAT;
      else if (bytes_ff[2] == codes.status)        push_rec.kind = KIND_STATUS;
      else if (bytes_ff[2] == codes.control)       push_rec.kind = KIND_CONTROL;
      else if (bytes_ff[2] == codes.query)         push_rec.kind = KIND_QUERY;
      else                                         push_rec.kind = KIND_UNKNOWN;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
         index_ff <= '0;
      end else if (accept) begin
         unique case (phase_ff)
            PH_GOT55: begin
               if (in_byte == HDR_SECOND) begin
                  phase_ff <= PH_BODY;
                  index_ff <= BODY_START;
               end else if (in_byte != HDR_FIRST) begin
                  phase_ff <= PH_HUNT;
               end
            end
            PH_BODY: begin
               if (index_ff >= LAST_INDEX || index_ff < BODY_START) begin
                  phase_ff <= PH_HUNT;
                  index_ff <= '0;
               end else begin
                  index_ff <= index_ff + 4'd1;
               end
            end
            default: begin
               phase_ff <= (in_byte == HDR_FIRST) ? PH_GOT55 : PH_HUNT;
               index_ff <= '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (accept && phase_ff == PH_BODY && index_ff >= BODY_START
          && index_ff < LAST_INDEX) begin
         bytes_ff[slot] <= in_byte;
      end
   end

endmodule

`default_nettype wire

/* src/shf_queue.sv */
// Two-entry frame queue between the front end and the back end.
// Depends on shf_pkg for the frame record type.
`default_nettype none

module shf_queue
   import shf_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           push,
   input  wire frame_rec_type  push_rec,
   input  wire logic           pop,
   output logic                full,
   output logic                head_valid,
   output frame_rec_type       head_rec
);

   frame_rec_type entry_ff [2];
   logic          wr_ptr_ff;
   logic          rd_ptr_ff;
   logic [1:0]    count_ff;
   logic          do_pop;

   assign full       = (count_ff == 2'd2);
   assign head_valid = (count_ff != 2'd0);
   assign head_rec   = entry_ff[rd_ptr_ff];
   assign do_pop     = pop && head_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (do_pop) rd_ptr_ff <= ~rd_ptr_ff;
         if (push && !do_pop) count_ff <= count_ff + 2'd1;
         else if (do_pop && !push) count_ff <= count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= push_rec;
   end

endmodule

`default_nettype wire

/* src/shf_back.sv */
// Back end: per-type payload store lookup, flag evaluation and result register.
// Depends on shf_pkg; pops frames from shf_queue.
`default_nettype none

module shf_back
   import shf_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           head_valid,
   input  wire frame_rec_type  head_rec,
   output logic                pop,
   input  wire logic           out_stall,
   output logic                out_valid,
   output frame_rec_type       out_rec,
   output logic                out_changed,
   output logic                out_first,
   output logic                out_reading_new
);

   logic [39:0]   store_mem [256];
   logic [39:0]   rd_data_ff;
   logic [39:0]   bypass_ff;
   logic          bypass_sel_ff;
   logic          a_valid_ff;
   frame_rec_type a_rec_ff;
   logic [255:0]  seen_ff;
   logic [7:0]    reading_ff [3];
   logic [2:0]    reading_valid_ff;
   logic          out_valid_ff;
   frame_rec_type out_rec_ff;
   logic          changed_ff;
   logic          first_ff;
   logic          reading_new_ff;

   logic          out_free;
   logic          a_move;
   logic [39:0]   pay_a;
   logic [39:0]   stored;
   logic          first_a;
   logic          changed_a;
   logic          has_reading;
   logic [1:0]    rkind;
   logic [7:0]    reading_a;
   logic          reading_new_a;

   assign out_free = !out_valid_ff || !out_stall;
   assign a_move   = a_valid_ff && out_free;
   assign pop      = head_valid && (!a_valid_ff || a_move);

   assign pay_a     = {a_rec_ff.sub, a_rec_ff.d1, a_rec_ff.d2, a_rec_ff.d3, a_rec_ff.t1};
   assign stored    = bypass_sel_ff ? bypass_ff : rd_data_ff;
   assign first_a   = !seen_ff[a_rec_ff.ftype];
   assign changed_a = !first_a && (stored != pay_a);

   assign has_reading   = (a_rec_ff.kind == KIND_HEARTBEAT) || (a_rec_ff.kind == KIND_STATUS)
                          || (a_rec_ff.kind == KIND_CONTROL);
   assign rkind         = a_rec_ff.kind[1:0];
   assign reading_a     = (a_rec_ff.kind == KIND_HEARTBEAT) ? a_rec_ff.t2 : a_rec_ff.t1;
   assign reading_new_a = has_reading
                          && (!reading_valid_ff[rkind] || reading_ff[rkind] != reading_a);

   assign out_valid       = out_valid_ff;
   assign out_rec         = out_rec_ff;
   assign out_changed     = changed_ff;
   assign out_first       = first_ff;
   assign out_reading_new = reading_new_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff       <= 1'b0;
         out_valid_ff     <= 1'b0;
         seen_ff          <= '0;
         reading_valid_ff <= '0;
      end else begin
         a_valid_ff   <= pop || (a_valid_ff && !a_move);
         out_valid_ff <= a_move || (out_valid_ff && out_stall);
         if (a_move) begin
            seen_ff[a_rec_ff.ftype] <= 1'b1;
            if (has_reading) reading_valid_ff[rkind] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         a_rec_ff      <= head_rec;
         bypass_sel_ff <= a_move && (a_rec_ff.ftype == head_rec.ftype);
         bypass_ff     <= pay_a;
      end
      if (a_move) begin
         out_rec_ff     <= a_rec_ff;
         changed_ff     <= changed_a;
         first_ff       <= first_a;
         reading_new_ff <= reading_new_a;
         if (has_reading) reading_ff[rkind] <= reading_a;
      end
   end

   always_ff @(posedge clock) begin
      if (a_move) store_mem[a_rec_ff.ftype] <= pay_a;
      if (pop) rd_data_ff <= store_mem[head_rec.ftype];
   end

endmodule

`default_nettype wire

/* src/sync_header_frame_classifier.sv */
// Sync header frame classifier top level: CSRs, front end, queue and back end.
// Depends on shf_pkg, shf_front, shf_queue and shf_back.
//
// Input channel (req_): one received byte per transaction, taken at any edge
// with req_valid high and req_stall low, so one per cycle unless stalled; the
// block hunts for header 0x55 0x35 and collects a fixed 10-byte frame.
// Result channel (rsp_): one transaction per completed frame, carrying the frame
// fields, the kind and the first-seen, payload-changed and reading-new flags.
// Throughput: one byte per cycle while req_stall is low; the back end retires
// one frame every cycle while rsp_stall is low, set by its one-read, one-write
// payload store. Each result passes the lookup stage and the result register.
// A two-entry queue sits between front and back: when rsp_stall is held, the
// result register, the lookup stage and the queue fill and only then is
// req_stall raised. Reset (synchronous, active high) returns the hunt to its
// start, clears the type-seen and reading-valid flags and loads the type codes
// 0, 1, 2, 3. CSRs are written via csr_write_enable/csr_index/csr_write_data;
// the user must do so only while idle, as the block does not enforce it.
`default_nettype none

module sync_header_frame_classifier
   import shf_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_write_enable,
   input  wire logic [1:0]  csr_index,
   input  wire logic [7:0]  csr_write_data,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_rx_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [2:0]       rsp_frame_kind,
   output logic [7:0]       rsp_frame_type,
   output logic [7:0]       rsp_length_byte,
   output logic [7:0]       rsp_sub_id,
   output logic [7:0]       rsp_data_one,
   output logic [7:0]       rsp_data_two,
   output logic [7:0]       rsp_data_three,
   output logic [7:0]       rsp_tail_one,
   output logic [7:0]       rsp_tail_two,
   output logic             rsp_payload_changed,
   output logic             rsp_first_of_type,
   output logic             rsp_reading_new
);

   code_set_type  codes_ff;
   logic          push;
   logic          queue_full;
   frame_rec_type push_rec;
   frame_rec_type head_rec;
   frame_rec_type out_rec;
   logic          head_valid;
   logic          pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         codes_ff.heartbeat <= 8'd0;
         codes_ff.status    <= 8'd1;
         codes_ff.control   <= 8'd2;
         codes_ff.query     <= 8'd3;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_HEARTBEAT: codes_ff.heartbeat <= csr_write_data;
            CSR_STATUS:    codes_ff.status    <= csr_write_data;
            CSR_CONTROL:   codes_ff.control   <= csr_write_data;
            CSR_QUERY:     codes_ff.query     <= csr_write_data;
            default:       codes_ff           <= codes_ff;
         endcase
      end
   end

   shf_front u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_valid),
      .in_byte    (req_rx_byte),
      .codes      (codes_ff),
      .queue_full (queue_full),
      .in_stall   (req_stall),
      .push       (push),
      .push_rec   (push_rec)
   );

   shf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_rec   (push_rec),
      .pop        (pop),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_rec   (head_rec)
   );

   shf_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head_valid      (head_valid),
      .head_rec        (head_rec),
      .pop             (pop),
      .out_stall       (rsp_stall),
      .out_valid       (rsp_valid),
      .out_rec         (out_rec),
      .out_changed     (rsp_payload_changed),
      .out_first       (rsp_first_of_type),
      .out_reading_new (rsp_reading_new)
   );

   assign rsp_frame_kind  = out_rec.kind;
   assign rsp_frame_type  = out_rec.ftype;
   assign rsp_length_byte = out_rec.len;
   assign rsp_sub_id      = out_rec.sub;
   assign rsp_data_one    = out_rec.d1;
   assign rsp_data_two    = out_rec.d2;
   assign rsp_data_three  = out_rec.d3;
   assign rsp_tail_one    = out_rec.t1;
   assign rsp_tail_two    = out_rec.t2;

endmodule

`default_nettype wire
